/* hw/rtl/rational_arithmetic_unit_core_assert.svh */
// Assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define RAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rau check failed");
// Next-cycle implication
`define RAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rau check failed");
`endif

/* hw/rtl/rau_pkg.sv */
//------------------------------------------------------------------------------
// rau_pkg
// Opcodes and sequencer states of the rational arithmetic unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package rau_pkg;
  localparam int ResBits = 63;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_EQ  = 4'd4, OP_NE  = 4'd5, OP_GT  = 4'd6, OP_LT  = 4'd7,
    OP_GE  = 4'd8, OP_LE  = 4'd9
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_FORM, ST_GCD_DIV, ST_GCD_SWAP,
    ST_RED_NUM, ST_RED_DEN, ST_DONE
  } state_t;
endpackage

/* hw/rtl/rational_arithmetic_unit_core.sv */
//------------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Signed fraction add/sub/mul/div with gcd reduction, and six compares.
//------------------------------------------------------------------------------
// Accept to result: multiply steps, the form step, then done for compares and
// faults; else a gcd check (zero ends there), Euclid steps, num and den reduce.
// One request at a time; busy is high from accept until out_valid, and the
// next request is taken in the cycle after each result.
// One shared restoring divider (one quotient bit per cycle) serves gcd and reduce.
// Reset (synchronous, rst_n low) returns the sequencer to idle; no stall.
`timescale 1ns / 1ps
module rational_arithmetic_unit_core #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [3:0]              in_req_type,
  input  logic [OPERAND_BITS-1:0] in_a_num,
  input  logic [OPERAND_BITS-1:0] in_a_den,
  input  logic                    in_a_neg,
  input  logic [OPERAND_BITS-1:0] in_b_num,
  input  logic [OPERAND_BITS-1:0] in_b_den,
  input  logic                    in_b_neg,
  output logic                    out_valid,
  output logic [62:0]             out_res_num,
  output logic [62:0]             out_res_den,
  output logic                    out_res_neg,
  output logic                    out_cmp_true,
  output logic                    out_error
);
  import rau_pkg::*;
  `include "rational_arithmetic_unit_core_assert.svh"

  localparam int W  = ResBits;
  localparam int PW = 2 * OPERAND_BITS;
  localparam int CW = $clog2(W + 1);

  state_t st_r, st_nxt;
  logic [3:0]              op_r;
  logic [OPERAND_BITS-1:0] an_r, ad_r, bn_r, bd_r;
  logic                    as_r, bs_r;
  logic [W-1:0]            x_r, y_r, z_r;   // products
  logic [W-1:0]            num_r, den_r, g_r, gy_r;
  logic                    neg_r, cmp_r, err_r;
  // shared divider: quotient/dividend shift register and remainder
  logic [W-1:0]            dq_r, rem_r, dv_r;
  logic [CW-1:0]           cnt_r;
  logic [OPERAND_BITS-1:0] ma, mb;
  logic [PW-1:0]           prod;
  logic [W:0]              trial;
  logic                    fault;

  // one shared multiplier, operands chosen by state
  always_comb begin
    case (st_r)
      ST_MUL1: begin ma = an_r; mb = bd_r; end
      ST_MUL2: begin ma = bn_r; mb = ad_r; end
      default: begin
        ma = ad_r;
        mb = (op_r == OP_DIV) ? bn_r : bd_r;
      end
    endcase
    if (st_r == ST_MUL1 && op_r == OP_MUL) mb = bn_r;
    prod  = ma * mb;
    trial = {rem_r, dq_r[W-1]} - {1'b0, dv_r};
  end

  assign fault = (op_r > OP_LE) || ad_r == '0 || bd_r == '0 ||
                 (op_r == OP_DIV && bn_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:     if (start) st_nxt = ST_MUL1;
      ST_MUL1:     st_nxt = ST_MUL2;
      ST_MUL2:     st_nxt = ST_MUL3;
      ST_MUL3:     st_nxt = ST_FORM;
      ST_FORM: begin
        if (fault || op_r >= OP_EQ) st_nxt = ST_DONE;
        else st_nxt = ST_GCD_SWAP;
      end
      ST_GCD_SWAP: begin
        if (g_r == '0) st_nxt = (num_r == '0) ? ST_DONE : ST_GCD_DIV;
        else st_nxt = (gy_r == '0) ? ST_RED_NUM : ST_GCD_DIV;
      end
      ST_GCD_DIV:  if (cnt_r == CW'(W - 1)) st_nxt = ST_GCD_SWAP;
      ST_RED_NUM:  if (cnt_r == CW'(W - 1)) st_nxt = ST_RED_DEN;
      ST_RED_DEN:  if (cnt_r == CW'(W - 1)) st_nxt = ST_DONE;
      ST_DONE:     st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        op_r <= in_req_type;
        an_r <= in_a_num; ad_r <= in_a_den;
        bn_r <= in_b_num; bd_r <= in_b_den;
        as_r <= in_a_neg && in_a_num != '0;
        bs_r <= in_b_neg && in_b_num != '0;
      end
      ST_MUL1: x_r <= W'(prod);
      ST_MUL2: y_r <= W'(prod);
      ST_MUL3: z_r <= W'(prod);
      ST_FORM: begin
        cmp_r <= 1'b0;
        err_r <= fault;
        num_r <= '0;
        neg_r <= 1'b0;
        den_r <= z_r;
        if (!fault) begin
          case (op_r)
            OP_ADD, OP_SUB: begin
              logic ys;
              ys = (op_r == OP_SUB) ? (!bs_r && bn_r != '0) : bs_r;
              if (as_r == ys) begin
                num_r <= x_r + y_r; neg_r <= as_r;
              end else if (x_r >= y_r) begin
                num_r <= x_r - y_r; neg_r <= as_r;
              end else begin
                num_r <= y_r - x_r; neg_r <= ys;
              end
            end
            OP_MUL, OP_DIV: begin
              num_r <= x_r; neg_r <= as_r != bs_r;
            end
            default: begin
              logic gt, eq;
              eq = (as_r == bs_r) && x_r == y_r;
              if (as_r != bs_r) gt = bs_r;
              else gt = as_r ? (x_r < y_r) : (x_r > y_r);
              case (op_r)
                OP_EQ:   cmp_r <= eq;
                OP_NE:   cmp_r <= !eq;
                OP_GT:   cmp_r <= gt;
                OP_LT:   cmp_r <= !gt && !eq;
                OP_GE:   cmp_r <= gt || eq;
                default: cmp_r <= !gt;
              endcase
            end
          endcase
        end
      end
      ST_GCD_SWAP: begin
        // first pass seeds g=num, y=den; later passes divide g by y
        if (g_r == '0) begin
          g_r <= num_r; gy_r <= den_r;
          dq_r <= num_r; dv_r <= den_r;
        end else if (gy_r == '0) begin
          // gcd found in g_r; set up numerator reduce
          dq_r <= num_r; dv_r <= g_r;
        end else begin
          dq_r <= g_r; dv_r <= gy_r;
        end
        rem_r <= '0; cnt_r <= '0;
      end
      ST_GCD_DIV, ST_RED_NUM, ST_RED_DEN: begin
        if (!trial[W]) begin
          rem_r <= trial[W-1:0]; dq_r <= {dq_r[W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[W-2:0], dq_r[W-1]}; dq_r <= {dq_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          cnt_r <= '0; rem_r <= '0;
          if (st_r == ST_GCD_DIV) begin
            gy_r <= trial[W] ? {rem_r[W-2:0], dq_r[W-1]} : trial[W-1:0];
            g_r  <= gy_r;
          end else if (st_r == ST_RED_NUM) begin
            num_r <= {dq_r[W-2:0], !trial[W]};
            dq_r <= den_r;
          end else begin
            den_r <= {dq_r[W-2:0], !trial[W]};
          end
        end
      end
      default: ;
    endcase
    if (st_r == ST_FORM) begin
      g_r <= '0; cnt_r <= '0;
    end
  end

  assign busy         = st_r != ST_IDLE;
  assign out_valid    = st_r == ST_DONE;
  assign out_res_num  = num_r;
  assign out_res_den  = (num_r == '0) ? W'(1) : den_r;
  assign out_res_neg  = neg_r && num_r != '0;
  assign out_cmp_true = cmp_r;
  assign out_error    = err_r;

  `RAU_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `RAU_ASSERT_IMP(a_err_zero, out_valid && out_error, out_res_num == '0 && !out_cmp_true)
  `RAU_ASSERT_IMP(a_cnt_range, st_r == ST_GCD_DIV || st_r == ST_RED_NUM || st_r == ST_RED_DEN, cnt_r <= CW'(W - 1))
  `RAU_ASSERT_NXT(a_one_shot, out_valid, !out_valid)
endmodule

/* test/testbench.sv */
//------------------------------------------------------------------------------
// testbench
// Checks the rational arithmetic unit: directed corner requests, then random
// fractions of mixed sizes, each result predicted and compared field by field.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import rau_pkg::*;

  localparam int OB = 31;
  localparam longint unsigned OMASK = (64'd1 << OB) - 1;
  localparam logic [OB-1:0] MAXMAG = OB'(OMASK);
  localparam int NUM_RANDOM = 1700;
  localparam longint unsigned CYCLE_LIMIT = 64'd50_000_000;

  typedef struct {
    logic [3:0]    op;
    logic [OB-1:0] an, ad, bn, bd;
    logic          as, bs;
  } frac_req_t;

  typedef struct packed {
    logic [62:0] num, den;
    logic        neg, cmp, err;
  } frac_res_t;

  class frac_scoreboard;
    frac_res_t pending[$];
    int        mismatches;
    int        checked;
    int        op_seen[16];

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    function automatic frac_res_t reduce(longint unsigned n, longint unsigned d,
                                         bit ng, bit c, bit e);
      frac_res_t r;
      longint unsigned g;
      if (n == 0) begin
        d  = 1;
        ng = 0;
      end else begin
        g = gcd64(n, d);
        n = n / g;
        d = d / g;
      end
      r.num = n[62:0];
      r.den = d[62:0];
      r.neg = ng;
      r.cmp = c;
      r.err = e;
      return r;
    endfunction

    // Exact rational result of one request.
    function automatic frac_res_t compute(frac_req_t q);
      longint unsigned an, ad, bn, bd, x, y;
      bit sa, sb, ys, t;
      int c;
      an = q.an & OMASK;
      ad = q.ad & OMASK;
      bn = q.bn & OMASK;
      bd = q.bd & OMASK;
      sa = q.as && an != 0;
      sb = q.bs && bn != 0;
      if (q.op > OP_LE || ad == 0 || bd == 0 || (q.op == OP_DIV && bn == 0))
        return reduce(0, 1, 0, 0, 1);
      x = an * bd;
      y = bn * ad;
      case (q.op)
        OP_ADD, OP_SUB: begin
          ys = (q.op == OP_SUB) ? (!sb && bn != 0) : sb;
          if (sa == ys) return reduce(x + y, ad * bd, sa, 0, 0);
          else if (x >= y) return reduce(x - y, ad * bd, sa, 0, 0);
          else return reduce(y - x, ad * bd, ys, 0, 0);
        end
        OP_MUL: return reduce(an * bn, ad * bd, sa != sb, 0, 0);
        OP_DIV: return reduce(x, ad * bn, sa != sb, 0, 0);
        default: ;
      endcase
      if (x == 0) sa = 0;
      if (y == 0) sb = 0;
      if (sa != sb) c = sa ? -1 : 1;
      else if (x == y) c = 0;
      else if (!sa) c = (x > y) ? 1 : -1;
      else c = (x > y) ? -1 : 1;
      case (q.op)
        OP_EQ:   t = (c == 0);
        OP_NE:   t = (c != 0);
        OP_GT:   t = (c > 0);
        OP_LT:   t = (c < 0);
        OP_GE:   t = (c >= 0);
        default: t = (c <= 0);
      endcase
      return reduce(0, 1, 0, t, 0);
    endfunction

    function void note_request(frac_req_t q);
      pending.push_back(compute(q));
      op_seen[q.op]++;
    endfunction

    function void check_result(frac_res_t r);
      frac_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result num=%0d den=%0d neg=%0b cmp=%0b err=%0b",
                   r.num, r.den, r.neg, r.cmp, r.err);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e != r) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: result %0d exp %0d/%0d neg=%0b cmp=%0b err=%0b, ",
                    "got %0d/%0d neg=%0b cmp=%0b err=%0b"},
                   checked, e.num, e.den, e.neg, e.cmp, e.err,
                   r.num, r.den, r.neg, r.cmp, r.err);
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [3:0]    in_req_type;
  logic [OB-1:0] in_a_num, in_a_den, in_b_num, in_b_den;
  logic          in_a_neg, in_b_neg;
  logic          out_valid;
  logic [62:0]   out_res_num, out_res_den;
  logic          out_res_neg, out_cmp_true, out_error;

  frac_scoreboard   sb = new();
  longint unsigned  cycles = 0;

  rational_arithmetic_unit_core #(.OPERAND_BITS(OB)) dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Note accepted requests and check strobed results.
  always @(posedge clk) begin
    frac_req_t q;
    frac_res_t r;
    if (rst_n && start && !busy) begin
      q.op = in_req_type;
      q.an = in_a_num;
      q.ad = in_a_den;
      q.as = in_a_neg;
      q.bn = in_b_num;
      q.bd = in_b_den;
      q.bs = in_b_neg;
      sb.note_request(q);
    end
    if (rst_n && out_valid) begin
      r.num = out_res_num;
      r.den = out_res_den;
      r.neg = out_res_neg;
      r.cmp = out_cmp_true;
      r.err = out_error;
      sb.check_result(r);
    end
  end

  task automatic send(frac_req_t q, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_type <= q.op;
    in_a_num    <= q.an;
    in_a_den    <= q.ad;
    in_a_neg    <= q.as;
    in_b_num    <= q.bn;
    in_b_den    <= q.bd;
    in_b_neg    <= q.bs;
    start       <= 1'b1;
    // hold until the request is taken
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [OB-1:0] rand_mag(bit nonzero);
    logic [OB-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = OB'($urandom_range(0, 12));
      3, 4, 5: v = OB'($urandom_range(0, 1000));
      6:       v = OB'($urandom_range(0, 65535));
      7:       v = OB'($urandom & OMASK);
      8:       v = OB'(OMASK - $urandom_range(0, 3));
      default: v = OB'(1) << $urandom_range(0, OB - 1);
    endcase
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction

  function automatic frac_req_t rand_req();
    frac_req_t q;
    q.op = ($urandom_range(0, 99) < 3) ? 4'($urandom_range(10, 15))
                                       : 4'($urandom_range(0, 9));
    q.an = rand_mag(0);
    q.bn = rand_mag(0);
    q.ad = rand_mag($urandom_range(0, 99) >= 3);
    q.bd = rand_mag($urandom_range(0, 99) >= 3);
    q.as = 1'($urandom_range(0, 1));
    q.bs = 1'($urandom_range(0, 1));
    // every so often compare a fraction with a scaled copy of itself
    if (q.op >= OP_EQ && $urandom_range(0, 3) == 0 && q.an < 1000 && q.ad < 1000) begin
      q.bn = OB'(q.an * 3);
      q.bd = OB'(q.ad * 3);
    end
    return q;
  endfunction

  function automatic frac_req_t mk(logic [3:0] op, logic [OB-1:0] an, logic [OB-1:0] ad,
                                   bit as, logic [OB-1:0] bn, logic [OB-1:0] bd, bit bs);
    frac_req_t q;
    q.op = op; q.an = an; q.ad = ad; q.as = as;
    q.bn = bn; q.bd = bd; q.bs = bs;
    return q;
  endfunction

  initial begin
    frac_req_t dir[$];
    int gap;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = '0;
    in_a_num    = '0;
    in_a_den    = '0;
    in_a_neg    = 1'b0;
    in_b_num    = '0;
    in_b_den    = '0;
    in_b_neg    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners: widest operands, signs, zeros, faults
    dir.push_back(mk(OP_ADD, MAXMAG, MAXMAG - OB'(1), 0, MAXMAG, MAXMAG, 0));
    dir.push_back(mk(OP_ADD, MAXMAG, 1, 1, MAXMAG, 1, 1));
    dir.push_back(mk(OP_SUB, 1, 3, 0, 1, 2, 0));
    dir.push_back(mk(OP_SUB, 5, 7, 1, 5, 7, 1));
    dir.push_back(mk(OP_MUL, MAXMAG, 1, 1, MAXMAG, 1, 0));
    dir.push_back(mk(OP_MUL, 0, 5, 1, 3, 4, 0));
    dir.push_back(mk(OP_DIV, 1, MAXMAG, 0, MAXMAG, 1, 1));
    dir.push_back(mk(OP_DIV, 3, 4, 0, 0, 4, 1));
    dir.push_back(mk(OP_EQ, 0, 3, 1, 0, 7, 0));
    dir.push_back(mk(OP_EQ, 2, 4, 1, 1, 2, 1));
    dir.push_back(mk(OP_NE, 2, 4, 0, 1, 2, 1));
    dir.push_back(mk(OP_GT, 0, 1, 1, 0, 1, 0));
    dir.push_back(mk(OP_GT, 1, 3, 1, 1, 2, 1));
    dir.push_back(mk(OP_LT, MAXMAG, 1, 1, 1, MAXMAG, 0));
    dir.push_back(mk(OP_GE, 0, 9, 0, 0, 2, 1));
    dir.push_back(mk(OP_LE, 7, 3, 0, 7, 3, 0));
    dir.push_back(mk(OP_ADD, 3, 0, 0, 1, 2, 0));
    dir.push_back(mk(OP_EQ, 1, 2, 0, 1, 0, 0));
    dir.push_back(mk(4'd10, 1, 2, 0, 1, 2, 0));
    dir.push_back(mk(4'd15, MAXMAG, MAXMAG, 1, MAXMAG, MAXMAG, 1));
    dir.push_back(mk(OP_SUB, 0, 1, 1, 0, 1, 1));
    dir.push_back(mk(OP_ADD, 1, 2, 1, 1, 2, 0));
    foreach (dir[i]) send(dir[i], (i % 3 == 0) ? 0 : $urandom_range(0, 11));

    // hold off until the unit has returned everything
    drain();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      gap = ((i / 200) % 2 == 1) ? 0 : $urandom_range(0, 11);
      send(rand_req(), gap);
    end
    drain();
    repeat (300) @(posedge clk);

    $display("covered %0d results: add %0d sub %0d mul %0d div %0d, %0d compares",
             sb.checked, sb.op_seen[OP_ADD], sb.op_seen[OP_SUB], sb.op_seen[OP_MUL],
             sb.op_seen[OP_DIV],
             sb.op_seen[4] + sb.op_seen[5] + sb.op_seen[6] + sb.op_seen[7]
             + sb.op_seen[8] + sb.op_seen[9]);
    $display("mismatches counted: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
